/* hdl/cfa_pkg.sv */
// cfa_pkg: shared types, codes and default sizes for the contiguous fit allocator
// depends on nothing; used by the ram, the datapath, the controller and the top level
`default_nettype none

package cfa_pkg;

    localparam int MAP_UNITS_DEF  = 1024;
    localparam int OWNER_BITS_DEF = 8;

    localparam int ACTION_W   = 1;
    localparam int OWNER_ID_W = 8;
    localparam int SIZE_W     = 11;
    localparam int STATUS_W   = 2;
    localparam int START_W    = 10;
    localparam int RELEASED_W = 11;
    localparam int POLICY_W   = 2;

    // request actions
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

    // fit policies
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd2;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED = 2'd2;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [OWNER_ID_W-1:0] owner_id;
        logic [SIZE_W-1:0]     block_size;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [START_W-1:0]    start_unit;
        logic [RELEASED_W-1:0] units_released;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic decide;
        logic fill;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic req_free;
        logic size_zero;
        logic scan_done;
        logic found;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* hdl/contiguous_fit_allocator.sv */
// contiguous_fit_allocator: top level, owner map allocator with first/best/next/worst fit
// depends on cfa_pkg, cfa_ctrl, cfa_datapath (and cfa_ram below it)
//
//  channel   direction   handshake                 payload
//  cfg       in          i_cfg_we                  i_cfg_data (fit policy)
//  request   in          i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  result    out         o_out_valid / i_out_stall o_out_data (t_out_item)
//
// after reset a clearing pass writes every map unit free, stall held high
// free request: one map beat per cycle through the map ram port
// allocate: scan then fill on the same ram port
// one request at a time; a finished result waits in the output register while the next
// request is accepted, and that request holds its result until the register drains
`default_nettype none

module contiguous_fit_allocator #(
    parameter int MAP_UNITS  = cfa_pkg::MAP_UNITS_DEF,
    parameter int OWNER_BITS = cfa_pkg::OWNER_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [cfa_pkg::POLICY_W-1:0] i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire cfa_pkg::t_in_item            i_in_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output cfa_pkg::t_out_item                o_out_data
);

    import cfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    cfa_datapath #(
        .MAP_UNITS  (MAP_UNITS),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

/* hdl/cfa_ram.sv */
// cfa_ram: generic single write port, single read port RAM with registered read
// depends on cfa_pkg for default sizes
`default_nettype none

module cfa_ram #(
    parameter int WIDTH = cfa_pkg::OWNER_BITS_DEF + 1,
    parameter int DEPTH = cfa_pkg::MAP_UNITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* hdl/cfa_datapath.sv */
// cfa_datapath: owner map RAM, scan pipeline, hole trackers, fill and result registers
// depends on cfa_pkg and cfa_ram; driven by cfa_ctrl through t_cmd / t_sts
`default_nettype none

module cfa_datapath #(
    parameter int MAP_UNITS  = cfa_pkg::MAP_UNITS_DEF,
    parameter int OWNER_BITS = cfa_pkg::OWNER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cfa_pkg::POLICY_W-1:0]    i_cfg_data,
    input  wire cfa_pkg::t_in_item               i_in_data,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output cfa_pkg::t_out_item                   o_out_data,
    input  wire cfa_pkg::t_cmd                   i_cmd,
    output cfa_pkg::t_sts                        o_sts
);

    import cfa_pkg::*;

    localparam int AW = $clog2(MAP_UNITS);
    localparam int CW = $clog2(MAP_UNITS + 1);
    localparam int LW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int MW = OWNER_BITS + 1;
    localparam logic [CW-1:0] MAP_END  = CW'(MAP_UNITS);
    localparam logic [CW-1:0] MAP_LAST = CW'(MAP_UNITS - 1);

    logic [POLICY_W-1:0]   r_policy;

    // latched request
    logic [ACTION_W-1:0]   r_action;
    logic [OWNER_BITS-1:0] r_owner;
    logic [SIZE_W-1:0]     r_size;
    logic [CW-1:0]         r_ptr;

    // scan pipeline
    logic [CW-1:0]         r_addr;
    logic                  r_end_sent;
    logic                  r_s_vld;
    logic [CW-1:0]         r_s_idx;

    // map ram
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [MW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [MW-1:0]         ram_rdata;

    // hole trackers
    logic [AW-1:0]         r_run_start,   n_run_start;
    logic [CW-1:0]         r_run_len,     n_run_len;
    logic                  r_found,       n_found;
    logic [AW-1:0]         r_pick,        n_pick;
    logic [CW-1:0]         r_pick_len,    n_pick_len;
    logic [CW-1:0]         r_best_slack,  n_best_slack;
    logic                  r_any_found,   n_any_found;
    logic [AW-1:0]         r_first_any,   n_first_any;
    logic                  r_after_found, n_after_found;
    logic [AW-1:0]         r_first_after, n_first_after;

    logic [CW-1:0]         r_released;
    logic [LW-1:0]         r_fcnt;
    logic [CW-1:0]         r_nfp;
    logic [CW-1:0]         r_used_cnt;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    logic [LW-1:0]         size_ext;
    logic                  s_end;
    logic                  s_used;
    logic [OWNER_BITS-1:0] s_owner;
    logic                  free_hit;
    logic                  run_fits;
    logic [CW-1:0]         slack;
    logic [LW-1:0]         fill_sum;
    logic                  dec_found;
    logic [AW-1:0]         dec_pick;
    logic                  out_free;

    assign size_ext = LW'(r_size);
    assign s_end    = (r_s_idx == MAP_END);
    assign s_used   = ram_rdata[OWNER_BITS];
    assign s_owner  = ram_rdata[OWNER_BITS-1:0];
    assign free_hit = i_cmd.scan && r_s_vld && !s_end && s_used &&
                      (s_owner == r_owner) && (r_action == ACT_FREE);
    assign run_fits = (r_run_len != '0) && (LW'(r_run_len) >= size_ext);
    assign slack    = CW'(LW'(r_run_len) - size_ext);
    assign fill_sum = LW'(r_pick) + r_fcnt;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        if (r_policy == POL_NEXT) begin
            dec_found = r_after_found || r_any_found;
            dec_pick  = r_after_found ? r_first_after : r_first_any;
        end else begin
            dec_found = r_found;
            dec_pick  = r_pick;
        end
    end

    // map write port: clearing pass, release of owner units, fill of a grant
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr[AW-1:0];
        ram_wdata = '0;
        if (i_cmd.clear) begin
            ram_we = 1'b1;
        end else if (free_hit) begin
            ram_we    = 1'b1;
            ram_waddr = r_s_idx[AW-1:0];
        end else if (i_cmd.fill) begin
            ram_we    = 1'b1;
            ram_waddr = fill_sum[AW-1:0];
            ram_wdata = {1'b1, r_owner};
        end
    end

    assign ram_raddr = (r_addr == MAP_END) ? '0 : r_addr[AW-1:0];

    cfa_ram #(
        .WIDTH (MW),
        .DEPTH (MAP_UNITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // hole tracking over one map beat per cycle
    always_comb begin
        n_run_start   = r_run_start;
        n_run_len     = r_run_len;
        n_found       = r_found;
        n_pick        = r_pick;
        n_pick_len    = r_pick_len;
        n_best_slack  = r_best_slack;
        n_any_found   = r_any_found;
        n_first_any   = r_first_any;
        n_after_found = r_after_found;
        n_first_after = r_first_after;
        if (i_cmd.start) begin
            n_run_len     = '0;
            n_found       = 1'b0;
            n_pick        = '0;
            n_any_found   = 1'b0;
            n_after_found = 1'b0;
        end else if (i_cmd.scan && r_s_vld && (r_action == ACT_ALLOC)) begin
            if (!s_end && !s_used) begin
                if (r_run_len == '0) begin
                    n_run_start = r_s_idx[AW-1:0];
                end
                n_run_len = r_run_len + 1'b1;
            end else begin
                if (run_fits) begin
                    unique case (r_policy)
                        POL_FIRST: begin
                            if (!r_found) begin
                                n_found    = 1'b1;
                                n_pick     = r_run_start;
                                n_pick_len = r_run_len;
                            end
                        end
                        POL_BEST: begin
                            if (!r_found || slack <= r_best_slack) begin
                                n_found      = 1'b1;
                                n_pick       = r_run_start;
                                n_pick_len   = r_run_len;
                                n_best_slack = slack;
                            end
                        end
                        POL_NEXT: begin
                            if (!r_any_found) begin
                                n_any_found = 1'b1;
                                n_first_any = r_run_start;
                            end
                            if (!r_after_found && (CW'(r_run_start) >= r_ptr)) begin
                                n_after_found = 1'b1;
                                n_first_after = r_run_start;
                            end
                        end
                        POL_WORST: begin
                            if (!r_found || r_run_len >= r_pick_len) begin
                                n_found    = 1'b1;
                                n_pick     = r_run_start;
                                n_pick_len = r_run_len;
                            end
                        end
                    endcase
                end
                n_run_len = '0;
            end
        end else if (i_cmd.decide) begin
            n_found = dec_found;
            n_pick  = dec_pick;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy    <= POL_FIRST;
            r_addr      <= '0;
            r_end_sent  <= 1'b0;
            r_s_vld     <= 1'b0;
            r_nfp       <= '0;
            r_used_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_data;
            end
            r_s_vld <= i_cmd.scan && !r_end_sent;
            if (i_cmd.clear) begin
                r_addr <= r_addr + 1'b1;
            end else if (i_cmd.start) begin
                r_addr     <= '0;
                r_end_sent <= 1'b0;
            end else if (i_cmd.scan && !r_end_sent) begin
                // one position past the map closes the last hole
                if (r_addr == MAP_END) begin
                    r_end_sent <= 1'b1;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (i_cmd.decide && dec_found) begin
                r_used_cnt <= r_used_cnt + CW'(r_size);
                r_nfp      <= CW'(LW'(dec_pick) + size_ext);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                if (r_action == ACT_FREE) begin
                    r_used_cnt <= r_used_cnt - r_released;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_run_start   <= n_run_start;
        r_run_len     <= n_run_len;
        r_found       <= n_found;
        r_pick        <= n_pick;
        r_pick_len    <= n_pick_len;
        r_best_slack  <= n_best_slack;
        r_any_found   <= n_any_found;
        r_first_any   <= n_first_any;
        r_after_found <= n_after_found;
        r_first_after <= n_first_after;
        r_s_idx       <= r_addr;
        if (i_cmd.start) begin
            r_action   <= i_in_data.action;
            r_owner    <= OWNER_BITS'(i_in_data.owner_id);
            r_size     <= i_in_data.block_size;
            r_ptr      <= (r_used_cnt == '0) ? '0 : r_nfp;
            r_released <= '0;
        end else if (free_hit) begin
            r_released <= r_released + 1'b1;
        end
        if (i_cmd.decide) begin
            r_fcnt <= '0;
        end else if (i_cmd.fill) begin
            r_fcnt <= r_fcnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            if (r_action == ACT_FREE) begin
                r_out_data.status         <= ST_FREED;
                r_out_data.start_unit     <= '0;
                r_out_data.units_released <= RELEASED_W'(r_released);
            end else if (r_found) begin
                r_out_data.status         <= ST_ALLOC;
                r_out_data.start_unit     <= START_W'(r_pick);
                r_out_data.units_released <= '0;
            end else begin
                r_out_data.status         <= ST_NOFIT;
                r_out_data.start_unit     <= '0;
                r_out_data.units_released <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_sts.clear_done = (r_addr == MAP_LAST);
    assign o_sts.req_free   = (r_action == ACT_FREE);
    assign o_sts.size_zero  = (r_size == '0);
    assign o_sts.scan_done  = r_s_vld && s_end;
    assign o_sts.found      = dec_found;
    assign o_sts.fill_last  = (r_fcnt == size_ext - 1'b1);
    assign o_sts.out_free   = out_free;

`ifndef ASSERT_OFF
    a_used_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_cnt <= MAP_END)
        else $error("held unit count beyond map size");

    a_fill_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (fill_sum < LW'(MAP_UNITS)))
        else $error("fill address beyond map");

    a_scan_beat_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_vld |-> $past(i_cmd.scan))
        else $error("scan beat without scan command");
`endif

endmodule

`default_nettype wire

/* hdl/cfa_ctrl.sv */
// cfa_ctrl: request sequencer for the allocator (clear, scan, decide, fill, result)
// depends on cfa_pkg for t_cmd / t_sts; drives cfa_datapath
`default_nettype none

module cfa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output cfa_pkg::t_cmd      o_cmd,
    input  wire cfa_pkg::t_sts i_sts
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_FREE     = 3'd3;
    localparam logic [2:0] S_ALLOC    = 3'd4;
    localparam logic [2:0] S_DECIDE   = 3'd5;
    localparam logic [2:0] S_FILL     = 3'd6;
    localparam logic [2:0] S_RESULT   = 3'd7;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.req_free) begin
                    n_state = S_FREE;
                end else if (i_sts.size_zero) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_FREE: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_ALLOC: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.found ? S_FILL : S_RESULT;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("result loaded over a waiting beat");

    a_nofit_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && !i_sts.found) |=> (r_state == S_RESULT))
        else $error("no-fit decision did not go to result");
`endif

endmodule

`default_nettype wire

/* tb/tb_contiguous_fit_allocator.sv */
// tb_contiguous_fit_allocator: self-checking bench for the owner map allocator
// drives directed then random allocate/free beats under all four fit policies
// depends on cfa_pkg and the contiguous_fit_allocator rtl
`timescale 1ns / 100ps

module tb_contiguous_fit_allocator;

    import cfa_pkg::*;

    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 12;
    localparam int MAP_UNITS    = MAP_UNITS_DEF;
    localparam int DRAIN_CYCLES = 2 * MAP_UNITS + 64;
    localparam int OWNER_POOL   = 10;
    localparam int PHASE_ITEMS  = 45;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_REPORTS  = 10;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [POLICY_W-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    t_in_item            i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    t_out_item           o_out_data;

    contiguous_fit_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // shadow of the owner map and allocator state
    bit                  unit_taken [MAP_UNITS];
    logic [7:0]          unit_holder [MAP_UNITS];
    int unsigned         fit_ptr;
    int unsigned         units_held;
    logic [POLICY_W-1:0] fit_policy_q;

    t_in_item    pending_reqs[$];
    t_out_item   expected_results[$];
    int unsigned issued_count;
    int unsigned accepted_count;
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          in_beat_done;
    logic [7:0]  owner_pool [OWNER_POOL];

    function automatic t_out_item predict_request(input t_in_item req);
        t_out_item   res;
        int unsigned released, size, ptr, slack;
        int unsigned run_start, run_len, pick, pick_len, best_slack;
        int unsigned first_any, first_after;
        bit          found, any_found, after_found, is_free;
        res         = '0;
        released    = 0;
        run_start   = 0;
        run_len     = 0;
        pick        = 0;
        pick_len    = 0;
        best_slack  = 0;
        first_any   = 0;
        first_after = 0;
        found       = 1'b0;
        any_found   = 1'b0;
        after_found = 1'b0;
        if (req.action == ACT_FREE) begin
            for (int i = 0; i < MAP_UNITS; i++) begin
                if (unit_taken[i] && unit_holder[i] == req.owner_id) begin
                    unit_taken[i]  = 1'b0;
                    unit_holder[i] = '0;
                    released++;
                end
            end
            units_held         -= released;
            res.status          = ST_FREED;
            res.units_released  = released[RELEASED_W-1:0];
            return res;
        end
        size = req.block_size;
        ptr  = (units_held == 0) ? 0 : fit_ptr;
        if (size != 0) begin
            // one extra step past the map closes a hole that runs to the top
            for (int i = 0; i <= MAP_UNITS; i++) begin
                is_free = 1'b0;
                if (i < MAP_UNITS) is_free = !unit_taken[i];
                if (is_free) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                end else begin
                    if (run_len != 0 && run_len >= size) begin
                        slack = run_len - size;
                        case (fit_policy_q)
                            POL_FIRST: begin
                                if (!found) begin
                                    found    = 1'b1;
                                    pick     = run_start;
                                    pick_len = run_len;
                                end
                            end
                            POL_BEST: begin
                                if (!found || slack <= best_slack) begin
                                    found      = 1'b1;
                                    pick       = run_start;
                                    pick_len   = run_len;
                                    best_slack = slack;
                                end
                            end
                            POL_NEXT: begin
                                if (!any_found) begin
                                    any_found = 1'b1;
                                    first_any = run_start;
                                end
                                if (!after_found && run_start >= ptr) begin
                                    after_found = 1'b1;
                                    first_after = run_start;
                                end
                            end
                            default: begin
                                if (!found || run_len >= pick_len) begin
                                    found    = 1'b1;
                                    pick     = run_start;
                                    pick_len = run_len;
                                end
                            end
                        endcase
                    end
                    run_len = 0;
                end
            end
            if (fit_policy_q == POL_NEXT) begin
                if (after_found) begin
                    found = 1'b1;
                    pick  = first_after;
                end else if (any_found) begin
                    found = 1'b1;
                    pick  = first_any;
                end
            end
        end
        if (!found) begin
            res.status = ST_NOFIT;
            return res;
        end
        for (int unsigned u = pick; u < pick + size; u++) begin
            if (u < MAP_UNITS) begin
                unit_taken[u]  = 1'b1;
                unit_holder[u] = req.owner_id;
            end
        end
        units_held     += size;
        fit_ptr         = pick + size;
        res.status      = ST_ALLOC;
        res.start_unit  = pick[START_W-1:0];
        return res;
    endfunction

    function automatic t_in_item random_request();
        t_in_item    req;
        int unsigned roll;
        roll           = $urandom_range(0, 99);
        req.action     = ACT_ALLOC;
        req.owner_id   = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
        req.block_size = SIZE_W'($urandom_range(1, 48));
        if (roll < 8) begin
            req.block_size = SIZE_W'($urandom_range(49, 400));
        end else if (roll >= 58 && roll < 88) begin
            req.action = ACT_FREE;
        end else if (roll >= 88) begin
            // noise: any owner, any size including zero and oversized
            req.action     = ($urandom_range(0, 1) == 0) ? ACT_ALLOC : ACT_FREE;
            req.owner_id   = OWNER_ID_W'($urandom_range(0, 255));
            req.block_size = SIZE_W'($urandom_range(0, 2047));
        end
        return req;
    endfunction

    task automatic push_request(input logic [ACTION_W-1:0] act, input int unsigned owner,
                                input int unsigned size);
        t_in_item req;
        req.action     = act;
        req.owner_id   = owner[OWNER_ID_W-1:0];
        req.block_size = size[SIZE_W-1:0];
        pending_reqs.push_back(req);
        issued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != issued_count || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_policy(input logic [POLICY_W-1:0] pol);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pol;
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        fit_policy_q  = pol;
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        if (fail_count < MAX_REPORTS)
            $display("%0t mismatch (%s): exp st %0d start %0d rel %0d, got st %0d start %0d rel %0d",
                     $realtime, what, want.status, want.start_unit, want.units_released,
                     got.status, got.start_unit, got.units_released);
        fail_count++;
    endtask

    // request side: accept at the rising edge, next beat set up at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            expected_results.push_back(predict_request(i_in_data));
            accepted_count++;
            in_beat_done = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (in_beat_done || !i_in_valid) begin
            in_beat_done = 1'b0;
            if (i_rst_n && pending_reqs.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_reqs.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result side
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", '0, o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.status !== want.status
                    || o_out_data.start_unit !== want.start_unit
                    || o_out_data.units_released !== want.units_released)
                    report_mismatch("field", want, o_out_data);
            end
        end
    end

    initial begin
        logic [POLICY_W-1:0] phase_policy [NUM_PHASES];
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = POL_FIRST;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        in_beat_done   = 1'b0;
        issued_count   = 0;
        accepted_count = 0;
        fail_count     = 0;
        fit_ptr        = 0;
        units_held     = 0;
        fit_policy_q   = POL_FIRST;
        send_idle_pct  = 21;
        recv_stall_pct = 49;
        for (int i = 0; i < MAP_UNITS; i++) begin
            unit_taken[i]  = 1'b0;
            unit_holder[i] = '0;
        end
        for (int i = 0; i < OWNER_POOL; i++) owner_pool[i] = OWNER_ID_W'($urandom_range(0, 255));
        phase_policy = '{POL_BEST, POL_NEXT, POL_WORST, POL_FIRST, POL_WORST, POL_NEXT};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_policy(POL_FIRST);

        // zero size, full map, oversized, free of an absent owner
        push_request(ACT_ALLOC, 0, 0);
        push_request(ACT_ALLOC, 255, 1024);
        push_request(ACT_ALLOC, 1, 1);
        push_request(ACT_FREE, 255, 0);
        push_request(ACT_FREE, 0, 2047);
        push_request(ACT_ALLOC, 0, 2047);
        push_request(ACT_ALLOC, 170, 1025);
        // open a hole low in the map
        push_request(ACT_ALLOC, 85, 1);
        push_request(ACT_ALLOC, 1, 100);
        push_request(ACT_ALLOC, 2, 10);
        push_request(ACT_ALLOC, 3, 200);
        push_request(ACT_FREE, 1, 0);
        push_request(ACT_ALLOC, 4, 50);
        wait_drained();

        // next fit picks up the pointer left by first fit, then an emptied map
        write_policy(POL_NEXT);
        push_request(ACT_ALLOC, 5, 20);
        push_request(ACT_ALLOC, 6, 40);
        push_request(ACT_ALLOC, 7, 700);
        push_request(ACT_FREE, 85, 0);
        push_request(ACT_FREE, 2, 0);
        push_request(ACT_FREE, 3, 0);
        push_request(ACT_FREE, 4, 0);
        push_request(ACT_FREE, 5, 0);
        push_request(ACT_FREE, 6, 0);
        push_request(ACT_ALLOC, 8, 5);
        push_request(ACT_ALLOC, 9, 1010);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 2) begin
                send_idle_pct  = 49;
                recv_stall_pct = 21;
            end else if (p == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            write_policy(phase_policy[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pending_reqs.push_back(random_request());
                issued_count++;
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
